// ===== rtl/tpss_pkg.sv =====
`default_nettype none
package tpss_pkg;

  // shared multiplier operand width and fixed datapath widths
  localparam int MUL_W    = 34;
  localparam int V_W      = 26;
  localparam int U_W      = 15;
  localparam int CORDIC_N = 23;

  // angles in 1/256 degree
  localparam logic [16:0] ANG_FULL  = 17'd92160;
  localparam logic [16:0] ANG_HALF  = 17'd46080;
  localparam logic [16:0] ANG_RIGHT = 17'd23040;

  // cordic angle bounds in degrees * 2^16
  localparam logic [24:0] Z_RIGHT = 25'd5898240;
  localparam logic [24:0] Z_HALF  = 25'd11796480;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_ANGLE = 2'd0,
    CFG_INERTIA   = 2'd1,
    CFG_STEP_LEN  = 2'd2
  } cfg_idx_t;

  localparam logic [7:0]  MAX_ANGLE_RST = 8'd50;
  localparam logic [16:0] INERTIA_RST   = 17'd16384;
  localparam logic [16:0] INERTIA_ONE   = 17'd65536;
  localparam logic [15:0] STEP_LEN_RST  = 16'd256;

  // control of the shared divide / square-root unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ds_ctl_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tract_peak_step_select_top.sv =====
`default_nettype none
// a peak whose vector or previous direction has zero length skips the angle
// computation; otherwise the shared divide / square-root unit runs three times
// per angle and up to four more times per kept peak (once only when the
// blended vector has zero length);
// one item at a time; rst_n is synchronous, active low, and restores the
// register defaults and clears the direction, point and running best state
module tract_peak_step_select_top #(
  parameter int COORD_BITS = 24,
  parameter int DIR_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // peak_x, peak_y, peak_z, point_x, point_y, point_z
  input  wire logic [((3*DIR_BITS+3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                  in_tlast,   // last_peak
  // first_peak, fiber_start, backward
  input  wire logic [2:0]            in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // next_x, next_y, next_z, dir_x, dir_y, dir_z
  output logic [((3*DIR_BITS+3*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // found
  output logic [0:0]                 out_tuser,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_addr,
  input  wire logic [16:0]           cfg_wdata
);

  localparam int C     = COORD_BITS;
  localparam int D     = DIR_BITS;
  localparam int SH    = (DIR_BITS > 16) ? DIR_BITS - 16 : 0;
  localparam int AW    = DIR_BITS - SH;
  localparam int MW    = tpss_pkg::MUL_W;
  localparam int PW    = 2 * tpss_pkg::MUL_W;
  localparam int VW    = tpss_pkg::V_W;
  localparam int UW    = tpss_pkg::U_W;
  localparam int BW    = DIR_BITS + 19;
  localparam int SW    = ((COORD_BITS > 23) ? COORD_BITS : 23) + 2;
  localparam int DSW   = ((DIR_BITS > 16) ? DIR_BITS : 16) + 1;
  localparam int TD_W  = ((3*DIR_BITS+3*COORD_BITS+7)/8)*8;
  localparam logic [4:0] CORD_LAST = 5'(tpss_pkg::CORDIC_N - 1);

  localparam logic signed [SW-1:0]  C_HI = SW'((longint'(1) <<< (C-1)) - 1);
  localparam logic signed [SW-1:0]  C_LO = -C_HI - SW'(1);
  localparam logic signed [DSW-1:0] D_HI = DSW'((longint'(1) <<< (D-1)) - 1);
  localparam logic signed [DSW-1:0] D_LO = -D_HI - DSW'(1);
  localparam logic signed [D-1:0]   D_MAX = D'((longint'(1) <<< (D-1)) - 1);
  localparam logic signed [D-1:0]   D_MIN = -D_MAX - D'(1);

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1 << 0,
    S_AMUL  = 23'd1 << 1,
    S_AWT   = 23'd1 << 2,
    S_NCHK  = 23'd1 << 3,
    S_SQ1   = 23'd1 << 4,
    S_SQ1W  = 23'd1 << 5,
    S_DIVW  = 23'd1 << 6,
    S_SQ2   = 23'd1 << 7,
    S_SQ2W  = 23'd1 << 8,
    S_CORD  = 23'd1 << 9,
    S_AFIN  = 23'd1 << 10,
    S_SEL   = 23'd1 << 11,
    S_BMUL  = 23'd1 << 12,
    S_BWT   = 23'd1 << 13,
    S_VMUL  = 23'd1 << 14,
    S_VWT   = 23'd1 << 15,
    S_SQ3   = 23'd1 << 16,
    S_SQ3W  = 23'd1 << 17,
    S_UDIV  = 23'd1 << 18,
    S_UDIVW = 23'd1 << 19,
    S_DMUL  = 23'd1 << 20,
    S_DWT   = 23'd1 << 21,
    S_FIN   = 23'd1 << 22
  } state_t;

  // what to do with the registered product
  typedef enum logic [2:0] {
    TG_NONE, TG_N1, TG_N2, TG_DOT, TG_BLA, TG_BLB, TG_VSQ, TG_DEL
  } tag_t;

  state_t state_r, state_nxt;

  // configuration
  logic [7:0]  max_r;
  logic [16:0] inertia_r;
  logic [15:0] step_r;

  // tracking state
  logic signed [D-1:0] prev_r [3];
  logic signed [C-1:0] held_r [3];
  logic signed [C-1:0] bpt_r  [3];
  logic signed [D-1:0] bdir_r [3];
  logic [16:0]         min_r;
  logic                any_r;

  // per-item work registers
  logic signed [D-1:0]  pk_r [3];
  logic                 last_r;
  logic [1:0]           lane_r;
  logic [4:0]           cnt_r;
  logic signed [PW-1:0] p_r;
  tag_t                 ptag_r;
  logic [1:0]           plane_r;
  logic [31:0]          n1_r;
  logic [31:0]          n2_r;
  logic signed [33:0]   dot_r;
  logic [30:0]          q_r;
  logic signed [33:0]   x_r;
  logic signed [33:0]   y_r;
  logic signed [31:0]   z_r;
  logic [16:0]          ang_r;
  logic [16:0]          kang_r;
  logic                 flip_r;
  logic signed [BW-1:0] t_r;
  logic signed [VW-1:0] v_r [3];
  logic [51:0]          vn2_r;
  logic [25:0]          n_r;
  logic signed [UW-1:0] u_r [3];

  // result register
  logic                out_valid_r;
  logic signed [C-1:0] onx_r  [3];
  logic signed [D-1:0] odir_r [3];
  logic                ofound_r;

  // shared unit
  tpss_pkg::ds_ctl_t ds_ctl;
  logic [63:0]       ds_num;
  logic [31:0]       ds_den;
  logic              ds_done;
  logic [31:0]       ds_res;

  tpss_divsqrt u_ds (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ds_ctl),
    .num  (ds_num),
    .den  (ds_den),
    .done (ds_done),
    .res  (ds_res)
  );

  logic signed [D-1:0] in_pk [3];
  logic signed [C-1:0] in_pt [3];
  logic                accept;
  logic                slot_free;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  // unpack input item
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pk[k] = in_tdata[k*D +: D];
      in_pt[k] = in_tdata[3*D + k*C +: C];
    end
  end

  // small datapath helpers
  logic [16:0]          w_eff;
  logic [16:0]          omw;
  logic signed [AW-1:0] a_sh;
  logic signed [AW-1:0] b_sh;
  logic [33:0]          dabs;
  logic [30:0]          qc;
  logic signed [33:0]   xs;
  logic signed [33:0]   ys;
  logic [21:0]          at;
  logic [24:0]          zc;
  logic [24:0]          zm;
  logic [25:0]          zr;
  logic [16:0]          lim;
  logic [16:0]          flp;
  logic                 keep_fwd;
  logic                 keep_flp;
  logic signed [BW-1:0] bsum;
  logic signed [VW-1:0] vsel;
  logic [VW-1:0]        vabs;
  logic signed [UW-1:0] uq;
  logic signed [PW-1:0] pabs;
  logic [30:0]          prnd;
  logic signed [SW-1:0] dlt;
  logic signed [SW-1:0] nx;
  logic signed [C-1:0]  nx_sat;
  logic signed [DSW-1:0] ud;
  logic signed [D-1:0]  ud_sat;

  always_comb begin
    w_eff = (inertia_r > tpss_pkg::INERTIA_ONE) ? tpss_pkg::INERTIA_ONE : inertia_r;
    omw   = tpss_pkg::INERTIA_ONE - w_eff;
    a_sh  = AW'(prev_r[lane_r] >>> SH);
    b_sh  = AW'(pk_r[lane_r] >>> SH);
    dabs  = dot_r[33] ? 34'(-dot_r) : 34'(dot_r);
    qc    = (ds_res > 32'h4000_0000) ? 31'h4000_0000 : ds_res[30:0];

    // cordic micro-rotation
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = tpss_pkg::atan_q16(cnt_r);

    // clamp, mirror and round the angle
    if (z_r < 0) zc = '0;
    else if (z_r > $signed({7'd0, tpss_pkg::Z_RIGHT})) zc = tpss_pkg::Z_RIGHT;
    else zc = z_r[24:0];
    zm = dot_r[33] ? (tpss_pkg::Z_HALF - zc) : zc;
    zr = {1'b0, zm} + 26'd128;

    // angle limit test
    lim      = {1'b0, max_r, 8'd0};
    flp      = tpss_pkg::ANG_HALF - ang_r;
    keep_fwd = (ang_r < lim) && (ang_r < min_r);
    keep_flp = (flp < lim) && (flp < min_r);

    // blend combine
    bsum = flip_r ? (t_r - $signed(p_r[BW-1:0])) : (t_r + $signed(p_r[BW-1:0]));

    // normalize divide operand
    vsel = v_r[lane_r];
    vabs = vsel[VW-1] ? VW'(-vsel) : VW'(vsel);
    uq   = $signed({1'b0, ds_res[UW-2:0]});

    // step rounding and saturation
    pabs = p_r[PW-1] ? -p_r : p_r;
    prnd = {1'b0, pabs[29:0]} + 31'd128;
    dlt  = p_r[PW-1] ? -SW'(prnd[30:8]) : SW'(prnd[30:8]);
    nx   = SW'(held_r[plane_r]) + (flip_r ? -dlt : dlt);
    if (nx > C_HI) nx_sat = C_HI[C-1:0];
    else if (nx < C_LO) nx_sat = C_LO[C-1:0];
    else nx_sat = nx[C-1:0];
    ud = flip_r ? -DSW'(u_r[plane_r]) : DSW'(u_r[plane_r]);
    if (ud > D_HI) ud_sat = D_HI[D-1:0];
    else if (ud < D_LO) ud_sat = D_LO[D-1:0];
    else ud_sat = ud[D-1:0];
  end

  // shared multiplier operand select
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  tag_t                 mtag;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mtag  = TG_NONE;
    case (state_r)
      S_AMUL: begin
        case (cnt_r[1:0])
          2'd0: begin
            mul_a = MW'(a_sh);
            mul_b = MW'(a_sh);
            mtag  = TG_N1;
          end
          2'd1: begin
            mul_a = MW'(b_sh);
            mul_b = MW'(b_sh);
            mtag  = TG_N2;
          end
          default: begin
            mul_a = MW'(a_sh);
            mul_b = MW'(b_sh);
            mtag  = TG_DOT;
          end
        endcase
      end
      S_NCHK: begin
        mul_a = MW'(n1_r);
        mul_b = MW'(n2_r);
      end
      S_DIVW: begin
        mul_a = MW'(qc);
        mul_b = MW'(qc);
      end
      S_BMUL: begin
        if (cnt_r[0]) begin
          mul_a = MW'(w_eff);
          mul_b = MW'(prev_r[lane_r]);
          mtag  = TG_BLB;
        end else begin
          mul_a = MW'(omw);
          mul_b = MW'(pk_r[lane_r]);
          mtag  = TG_BLA;
        end
      end
      S_VMUL: begin
        mul_a = MW'(vsel);
        mul_b = MW'(vsel);
        mtag  = TG_VSQ;
      end
      S_DMUL: begin
        mul_a = MW'(u_r[lane_r]);
        mul_b = MW'(step_r);
        mtag  = TG_DEL;
      end
      default: begin
        mtag = TG_NONE;
      end
    endcase
  end

  // shared unit requests
  always_comb begin
    ds_ctl.start     = 1'b0;
    ds_ctl.sqrt_mode = 1'b0;
    ds_num           = '0;
    ds_den           = '0;
    case (state_r)
      S_SQ1: begin
        ds_ctl.start     = 1'b1;
        ds_ctl.sqrt_mode = 1'b1;
        ds_num           = p_r[63:0];
      end
      S_SQ1W: begin
        ds_ctl.start = ds_done;
        ds_num       = {2'b00, dabs[31:0], 30'd0};
        ds_den       = ds_res;
      end
      S_SQ2: begin
        ds_ctl.start     = 1'b1;
        ds_ctl.sqrt_mode = 1'b1;
        ds_num           = (64'd1 << 60) - {3'b000, p_r[60:0]};
      end
      S_SQ3: begin
        ds_ctl.start     = 1'b1;
        ds_ctl.sqrt_mode = 1'b1;
        ds_num           = {12'd0, vn2_r};
      end
      S_UDIV: begin
        ds_ctl.start = 1'b1;
        ds_num       = {26'd0, vabs, 12'd0} + {39'd0, n_r[25:1]};
        ds_den       = {6'd0, n_r};
      end
      default: begin
        ds_ctl.start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_AMUL;
      S_AMUL:  if (lane_r == 2'd2 && cnt_r == 5'd2) state_nxt = S_AWT;
      S_AWT:   state_nxt = S_NCHK;
      S_NCHK:  state_nxt = (n1_r == '0 || n2_r == '0) ? S_SEL : S_SQ1;
      S_SQ1:   state_nxt = S_SQ1W;
      S_SQ1W:  if (ds_done) state_nxt = S_DIVW;
      S_DIVW:  if (ds_done) state_nxt = S_SQ2;
      S_SQ2:   state_nxt = S_SQ2W;
      S_SQ2W:  if (ds_done) state_nxt = S_CORD;
      S_CORD:  if (cnt_r == CORD_LAST) state_nxt = S_AFIN;
      S_AFIN:  state_nxt = S_SEL;
      S_SEL:   state_nxt = (keep_fwd || keep_flp) ? S_BMUL : S_FIN;
      S_BMUL:  if (lane_r == 2'd2 && cnt_r == 5'd1) state_nxt = S_BWT;
      S_BWT:   state_nxt = S_VMUL;
      S_VMUL:  if (lane_r == 2'd2) state_nxt = S_VWT;
      S_VWT:   state_nxt = S_SQ3;
      S_SQ3:   state_nxt = S_SQ3W;
      S_SQ3W:  if (ds_done) state_nxt = (ds_res == '0) ? S_DMUL : S_UDIV;
      S_UDIV:  state_nxt = S_UDIVW;
      S_UDIVW: if (ds_done) state_nxt = (lane_r == 2'd2) ? S_DMUL : S_UDIV;
      S_DMUL:  if (lane_r == 2'd2) state_nxt = S_DWT;
      S_DWT:   state_nxt = S_FIN;
      S_FIN:   if (!last_r || slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= '0;
      cnt_r       <= '0;
      ptag_r      <= TG_NONE;
      out_valid_r <= 1'b0;
      max_r       <= tpss_pkg::MAX_ANGLE_RST;
      inertia_r   <= tpss_pkg::INERTIA_RST;
      step_r      <= tpss_pkg::STEP_LEN_RST;
      min_r       <= tpss_pkg::ANG_FULL;
      any_r       <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_r[k] <= '0;
        held_r[k] <= '0;
        bpt_r[k]  <= '0;
        bdir_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ptag_r  <= mtag;

      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          tpss_pkg::CFG_MAX_ANGLE: max_r     <= cfg_wdata[7:0];
          tpss_pkg::CFG_INERTIA:   inertia_r <= cfg_wdata;
          tpss_pkg::CFG_STEP_LEN:  step_r    <= cfg_wdata[15:0];
          default:                 max_r     <= max_r;
        endcase
      end

      // result handoff
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      // kept peak lands in the running best
      if (ptag_r == TG_DEL) begin
        bpt_r[plane_r]  <= nx_sat;
        bdir_r[plane_r] <= ud_sat;
      end

      case (state_r)
        S_IDLE: begin
          lane_r <= '0;
          cnt_r  <= '0;
          if (accept) begin
            if (in_tuser[0]) begin
              min_r <= tpss_pkg::ANG_FULL;
              any_r <= 1'b0;
              for (int k = 0; k < 3; k++) begin
                held_r[k] <= in_pt[k];
                bpt_r[k]  <= '0;
                bdir_r[k] <= '0;
              end
            end
            if (in_tuser[1]) begin
              for (int k = 0; k < 3; k++) begin
                if (in_tuser[2]) prev_r[k] <= (in_pk[k] == D_MIN) ? D_MAX : -in_pk[k];
                else prev_r[k] <= in_pk[k];
              end
            end
          end
        end
        S_AMUL: begin
          if (cnt_r == 5'd2) begin
            cnt_r  <= '0;
            lane_r <= lane_r + 2'd1;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_SQ2W: begin
          cnt_r <= '0;
        end
        S_CORD: begin
          cnt_r <= cnt_r + 5'd1;
        end
        S_SEL: begin
          lane_r <= '0;
          cnt_r  <= '0;
        end
        S_BMUL: begin
          if (cnt_r == 5'd1) begin
            cnt_r  <= '0;
            lane_r <= lane_r + 2'd1;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_BWT: begin
          lane_r <= '0;
        end
        S_VMUL: begin
          lane_r <= lane_r + 2'd1;
        end
        S_SQ3W: begin
          lane_r <= '0;
        end
        S_UDIVW: begin
          if (ds_done) lane_r <= lane_r + 2'd1;
        end
        S_DMUL: begin
          lane_r <= lane_r + 2'd1;
        end
        S_DWT: begin
          min_r <= kang_r;
          any_r <= 1'b1;
        end
        S_FIN: begin
          if (last_r && slot_free) begin
            out_valid_r <= 1'b1;
            for (int k = 0; k < 3; k++) prev_r[k] <= any_r ? bdir_r[k] : '0;
          end
        end
        default: begin
          lane_r <= lane_r;
        end
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    p_r     <= mul_a * mul_b;
    plane_r <= lane_r;

    // product consumers
    case (ptag_r)
      TG_N1:   n1_r  <= n1_r + p_r[31:0];
      TG_N2:   n2_r  <= n2_r + p_r[31:0];
      TG_DOT:  dot_r <= dot_r + p_r[33:0];
      TG_BLA:  t_r   <= p_r[BW-1:0];
      TG_BLB:  v_r[plane_r] <= bsum[D+17:D-8];
      TG_VSQ:  vn2_r <= vn2_r + p_r[51:0];
      default: t_r   <= t_r;
    endcase

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n1_r   <= '0;
          n2_r   <= '0;
          dot_r  <= '0;
          last_r <= in_tlast;
          for (int k = 0; k < 3; k++) pk_r[k] <= in_pk[k];
        end
      end
      S_NCHK: begin
        ang_r <= tpss_pkg::ANG_RIGHT;
      end
      S_DIVW: begin
        if (ds_done) q_r <= qc;
      end
      S_SQ2W: begin
        if (ds_done) begin
          x_r <= 34'(q_r);
          y_r <= 34'(ds_res);
          z_r <= '0;
        end
      end
      S_CORD: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + $signed({10'd0, at});
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - $signed({10'd0, at});
        end
      end
      S_AFIN: begin
        ang_r <= zr[24:8];
      end
      S_SEL: begin
        vn2_r  <= '0;
        flip_r <= !keep_fwd;
        kang_r <= keep_fwd ? ang_r : flp;
      end
      S_SQ3W: begin
        if (ds_done) begin
          n_r <= ds_res[25:0];
          if (ds_res == '0) begin
            for (int k = 0; k < 3; k++) u_r[k] <= '0;
          end
        end
      end
      S_UDIVW: begin
        if (ds_done) u_r[lane_r] <= vsel[VW-1] ? -uq : uq;
      end
      S_FIN: begin
        if (last_r && slot_free) begin
          ofound_r <= any_r;
          for (int k = 0; k < 3; k++) begin
            onx_r[k]  <= any_r ? bpt_r[k] : '0;
            odir_r[k] <= any_r ? bdir_r[k] : '0;
          end
        end
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  // pack result item
  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < 3; k++) begin
      out_tdata[k*C +: C]       = onx_r[k];
      out_tdata[3*C + k*D +: D] = odir_r[k];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = ofound_r;

endmodule
`default_nettype wire

// ===== rtl/tpss_divsqrt.sv =====
`default_nettype none
// shared shift-subtract unit: 64/32 divide or 64-bit floor square root,
// one result bit per cycle
module tpss_divsqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tpss_pkg::ds_ctl_t ctl,
  input  wire logic [63:0]       num,
  input  wire logic [31:0]       den,
  output logic                   done,
  output logic [31:0]            res
);

  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic [4:0]  cnt_r;
  logic [35:0] rem_r;
  logic [63:0] src_r;
  logic [31:0] den_r;
  logic [31:0] acc_r;

  logic [35:0] cat;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // one compare and subtract serves both modes
  always_comb begin
    if (mode_r) begin
      cat   = {rem_r[33:0], src_r[63:62]};
      trial = {2'b00, acc_r, 2'b01};
    end else begin
      cat   = {rem_r[34:0], src_r[63]};
      trial = {4'b0000, den_r};
    end
    ge   = (cat >= trial);
    diff = cat - trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_r <= ctl.sqrt_mode;
      den_r  <= den;
      acc_r  <= '0;
      if (ctl.sqrt_mode) begin
        rem_r <= '0;
        src_r <= num;
      end else begin
        rem_r <= {4'b0000, num[63:32]};
        src_r <= {num[31:0], 32'd0};
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff : cat;
      acc_r <= {acc_r[30:0], ge};
      src_r <= mode_r ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule
`default_nettype wire

// ===== dv/tb_tract_peak_step_select_top.sv =====
`default_nettype none
module tb_tract_peak_step_select_top;
  import tpss_pkg::*;

  localparam int CB = 24;
  localparam int DB = 16;
  localparam int TDW = ((3*DB+3*CB+7)/8)*8;
  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE = 400;

  typedef struct {
    logic signed [DB-1:0] peak[3];
    logic signed [CB-1:0] pnt[3];
    bit first_peak;
    bit last_peak;
    bit fiber_start;
    bit backward;
  } peak_item_t;

  typedef struct {
    logic signed [CB-1:0] nxt[3];
    logic signed [DB-1:0] dir[3];
    bit found;
  } step_result_t;

  // step predictor plus expected-step queue
  class step_scoreboard;
    bit [7:0]  max_angle = MAX_ANGLE_RST;
    bit [16:0] inertia = INERTIA_RST;
    bit [15:0] step_len = STEP_LEN_RST;
    longint prev_dir[3];
    longint best_pt[3];
    longint best_dir[3];
    longint held_pt[3];
    longint min_ang = 92160;
    bit any_found;
    step_result_t step_q[$];
    int errors;
    int n_steps;
    int n_found;
    longint atan_deg[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

    function void set_reg(cfg_idx_t idx, bit [16:0] val);
      case (idx)
        CFG_MAX_ANGLE: max_angle = val[7:0];
        CFG_INERTIA:   inertia = val;
        CFG_STEP_LEN:  step_len = val[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // divide with rounding half away from zero
    function longint round_div(longint num, longint unsigned den);
      longint unsigned m, q;
      m = num < 0 ? longint'(-num) : num;
      q = (m + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint clip(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // angle between two vectors in 1/256 degree
    function longint angle_256(longint a[3], longint b[3]);
      longint unsigned n1, n2, q, mag;
      longint dot, x, y, z, xs, ys;
      n1 = 0; n2 = 0; dot = 0; z = 0;
      for (int i = 0; i < 3; i++) begin
        n1 += a[i] * a[i];
        n2 += b[i] * b[i];
        dot += a[i] * b[i];
      end
      if (n1 == 0 || n2 == 0) return 23040;
      mag = (dot < 0 ? longint'(-dot) : dot);
      mag = mag << 30;
      q = mag / root(n1 * n2);
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      x = q;
      y = root((64'd1 << 60) - q * q);
      for (int i = 0; i < 23; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z += atan_deg[i];
        end else begin
          x = x - ys; y = y + xs; z -= atan_deg[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(90) << 16)) z = longint'(90) << 16;
      if (dot < 0) z = (longint'(180) << 16) - z;
      return (z + 128) >>> 8;
    endfunction

    // blend with previous direction, normalize, step the point
    function void take_peak(longint d[3], bit flip, longint ang);
      longint w, p, v[3], u, delta;
      longint unsigned n2, n;
      w = inertia > 65536 ? 65536 : inertia;
      n2 = 0;
      for (int i = 0; i < 3; i++) begin
        p = w * prev_dir[i];
        v[i] = ((65536 - w) * d[i] + (flip ? -p : p)) >>> (DB - 8);
        n2 += v[i] * v[i];
      end
      n = root(n2);
      for (int i = 0; i < 3; i++) begin
        u = n == 0 ? 0 : round_div(v[i] * 4096, n);
        delta = round_div(u * longint'(step_len), 256);
        best_pt[i] = clip(held_pt[i] + (flip ? -delta : delta), CB);
        best_dir[i] = clip(flip ? -u : u, DB);
      end
      min_ang = ang;
      any_found = 1;
    endfunction

    function void note_peak(peak_item_t it);
      longint d[3], ang, flipped, lim;
      step_result_t r;
      for (int i = 0; i < 3; i++) d[i] = it.peak[i];
      if (it.first_peak) begin
        for (int i = 0; i < 3; i++) begin
          held_pt[i] = it.pnt[i];
          best_pt[i] = 0;
          best_dir[i] = 0;
        end
        min_ang = 92160;
        any_found = 0;
      end
      if (it.fiber_start)
        for (int i = 0; i < 3; i++) prev_dir[i] = it.backward ? clip(-d[i], DB) : d[i];
      ang = angle_256(prev_dir, d);
      flipped = 46080 - ang;
      lim = longint'(max_angle) * 256;
      if (ang < lim && ang < min_ang) take_peak(d, 0, ang);
      else if (flipped < lim && flipped < min_ang) take_peak(d, 1, flipped);
      if (!it.last_peak) return;
      for (int i = 0; i < 3; i++) begin
        r.nxt[i] = any_found ? best_pt[i] : 0;
        r.dir[i] = any_found ? best_dir[i] : 0;
        prev_dir[i] = r.dir[i];
      end
      r.found = any_found;
      step_q.push_back(r);
    endfunction

    function void check_step(step_result_t got);
      step_result_t e;
      n_steps++;
      if (got.found) n_found++;
      if (step_q.size() == 0) begin
        $error("step result with nothing expected");
        errors++;
        return;
      end
      e = step_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.nxt[i] !== e.nxt[i]) begin
          $error("next[%0d]: expected %0d, got %0d", i, e.nxt[i], got.nxt[i]);
          errors++;
        end
        if (got.dir[i] !== e.dir[i]) begin
          $error("dir[%0d]: expected %0d, got %0d", i, e.dir[i], got.dir[i]);
          errors++;
        end
      end
      if (got.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [TDW-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [16:0] cfg_wdata = '0;

  step_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cnt = 0;
  int n_peaks = 0;
  logic signed [DB-1:0] last_dir[3];
  bit fiber_bw = 0;

  tract_peak_step_select_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    step_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 3; i++) begin
        got.nxt[i] = out_tdata[i*CB +: CB];
        got.dir[i] = out_tdata[3*CB + i*DB +: DB];
      end
      got.found = out_tuser[0];
      sb.check_step(got);
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_peak(peak_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    for (int i = 0; i < 3; i++) begin
      in_tdata[i*DB +: DB] <= it.peak[i];
      in_tdata[3*DB + i*CB +: CB] <= it.pnt[i];
    end
    in_tlast <= it.last_peak;
    in_tuser <= {it.backward, it.fiber_start, it.first_peak};
    do @(posedge clk); while (!in_tready);
    sb.note_peak(it);
    n_peaks++;
  endtask

  // quiet the input, drain expected steps, let in-flight peaks finish
  task automatic drain;
    in_tvalid <= 0;
    while (sb.step_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(bit [7:0] ang, bit [16:0] w, bit [15:0] stp);
    cfg_idx_t idx[3] = '{CFG_MAX_ANGLE, CFG_INERTIA, CFG_STEP_LEN};
    bit [16:0] val[3];
    val[0] = ang; val[1] = w; val[2] = stp;
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 0;
  endtask

  function automatic peak_item_t mk(int px, int py, int pz, int x, int y, int z,
                                    bit fp, bit lp, bit fs, bit bw);
    peak_item_t it;
    it.peak[0] = px; it.peak[1] = py; it.peak[2] = pz;
    it.pnt[0] = x; it.pnt[1] = y; it.pnt[2] = z;
    it.first_peak = fp; it.last_peak = lp; it.fiber_start = fs; it.backward = bw;
    return it;
  endfunction

  // mostly unit-scale vectors, some full-range, a few extremes
  function automatic logic signed [DB-1:0] rand_comp(int kind);
    int pick;
    pick = $urandom_range(0, 2);
    if (kind < 6) return $signed($urandom_range(0, 8192)) - 4096;
    if (kind < 9) return $urandom;
    return pick == 0 ? -32768 : (pick == 1 ? 32767 : 0);
  endfunction

  function automatic logic signed [CB-1:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 2097152)) - 1048576;
  endfunction

  // voxels of one to four peaks, some near the previous direction, some broken
  task automatic random_voxels(int count);
    int sent, n, kind, noise;
    peak_item_t it;
    sent = 0;
    while (sent < count) begin
      n = $urandom_range(1, 4);
      noise = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) fiber_bw = $urandom_range(0, 1);
      for (int k = 0; k < n; k++) begin
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
          if (kind < 3) it.peak[i] = last_dir[i] + $signed($urandom_range(0, 2048)) - 1024;
          else it.peak[i] = rand_comp(kind);
          it.pnt[i] = rand_coord();
        end
        it.first_peak = (k == 0) && !(noise == 0);
        it.last_peak = (k == n - 1) && !(noise == 1);
        it.fiber_start = (k == 0 && $urandom_range(0, 4) == 0) || (noise == 2 && k == n - 1);
        it.backward = fiber_bw;
        send_peak(it);
        for (int i = 0; i < 3; i++) last_dir[i] = it.peak[i];
        sent++;
      end
    end
  endtask

  initial begin
    bit [7:0] ang_set[5] = '{90, 180, 0, 255, 0};
    bit [16:0] w_set[5] = '{0, 65536, 131071, 32768, 0};
    bit [15:0] stp_set[5] = '{1, 65535, 0, 512, 0};
    int mode;
    for (int i = 0; i < 3; i++) last_dir[i] = 4096;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default registers
    tx_idle_pct = 12; rx_idle_pct = 50;
    send_peak(mk(4096, 0, 0, 0, 0, 0, 1, 1, 1, 0));
    send_peak(mk(4000, 500, 0, 4096, 0, 0, 1, 1, 0, 0));
    send_peak(mk(0, 0, 0, 100, 200, 300, 1, 1, 0, 0));          // zero-length peak
    send_peak(mk(4096, 0, 0, 0, 0, 0, 1, 1, 1, 0));
    send_peak(mk(0, 4096, 0, 0, 0, 0, 1, 1, 0, 0));             // right angle: not found
    send_peak(mk(4096, 0, 0, 0, 0, 0, 1, 1, 1, 0));
    send_peak(mk(-4000, 300, 0, 5000, -5000, 7, 1, 1, 0, 0));   // flipped peak
    send_peak(mk(-32768, -32768, -32768, 0, 0, 0, 1, 1, 1, 1)); // negation saturates
    send_peak(mk(32767, 32767, 32767, 8388607, -8388608, 0, 1, 0, 0, 0));
    send_peak(mk(1000, 2000, 3000, 1, 2, 3, 0, 0, 0, 0));
    send_peak(mk(-32768, 32767, 0, 9, 9, 9, 0, 1, 0, 0));
    send_peak(mk(2000, 2000, 0, -8388608, 8388607, 0, 0, 1, 0, 0)); // no first peak
    send_peak(mk(3000, 100, 100, 77, 77, 77, 1, 0, 0, 0));
    send_peak(mk(3500, 50, 0, 0, 0, 0, 0, 1, 0, 0));
    drain();

    // directed: any turn allowed, half inertia, longest step
    tx_idle_pct = 50; rx_idle_pct = 12;
    write_regs(255, 32768, 65535);
    send_peak(mk(4096, 0, 0, 0, 0, 0, 1, 1, 1, 0));
    send_peak(mk(-4096, 0, 0, 1000, 1000, 1000, 1, 1, 0, 0));   // blend cancels
    send_peak(mk(4096, 0, 0, 8388000, 0, 0, 1, 1, 1, 0));       // x saturates high
    send_peak(mk(-4096, 0, 0, -8388000, 0, 0, 1, 1, 1, 1));     // backward start, blend cancels
    send_peak(mk(0, 0, 4096, 0, 0, -8388608, 1, 1, 1, 1));
    send_peak(mk(100, -4000, 9, 0, 0, 0, 1, 1, 0, 0));
    drain();

    // random phases, rotating idle patterns and register settings
    for (int ph = 0; ph < 5; ph++) begin
      mode = ph % 3;
      tx_idle_pct = mode == 0 ? 12 : (mode == 1 ? 50 : 0);
      rx_idle_pct = mode == 0 ? 50 : (mode == 1 ? 12 : 0);
      if (ph == 4)
        write_regs($urandom_range(20, 180), $urandom_range(0, 65536), $urandom_range(1, 4096));
      else
        write_regs(ang_set[ph], w_set[ph], stp_set[ph]);
      random_voxels(ph == 2 ? 60 : 160);
      drain();
    end

    $display("run: %0d peaks sent, %0d steps checked, %0d with a direction found",
             n_peaks, sb.n_steps, sb.n_found);
    $display("covered angle limits 0..255, inertia 0..131071, step length 0..65535");
    if (sb.errors == 0 && sb.step_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
